FILE: hw/rtl/lsas_pkg.sv
`default_nettype none
package lsas_pkg;

  // configuration register indexes
  localparam logic [1:0] RegCrank = 2'd0;
  localparam logic [1:0] RegLink  = 2'd1;
  localparam logic [1:0] RegArm   = 2'd2;

  // angle word: signed q16 degrees
  localparam int ZW = 26;
  // vectoring input and working widths
  localparam int VIW = 33;
  localparam int VDW = 45;
  // vectoring inputs are scaled up until one component reaches this bit
  localparam int NormBit = 40;

  localparam logic signed [ZW-1:0] Deg90  = 26'sd5898240;
  localparam logic signed [ZW-1:0] Deg180 = 26'sd11796480;
  localparam logic signed [ZW-1:0] Deg270 = 26'sd17694720;

  // atan(2^-i) in q16 degrees
  function automatic logic [21:0] atan_deg(input int idx);
    logic [21:0] v;
    case (idx)
      0: v = 22'd2949120;
      1: v = 22'd1740967;
      2: v = 22'd919879;
      3: v = 22'd466945;
      4: v = 22'd234379;
      5: v = 22'd117304;
      6: v = 22'd58666;
      7: v = 22'd29335;
      8: v = 22'd14668;
      9: v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lsas_isqrt.sv
`default_nettype none
module lsas_isqrt #(
  parameter int W  = 24,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [2*W-1:0] in_val,
  input  logic [SW-1:0]  in_side,
  output logic           out_vld,
  output logic [W-1:0]   out_root,
  output logic [SW-1:0]  out_side
);

  logic           vld_r  [W];
  logic [2*W-1:0] rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [SW-1:0]  side_r [W];

  // one result bit per stage, msb first
  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    logic           vld_i;
    logic [2*W-1:0] rem_i;
    logic [W-1:0]   root_i;
    logic [SW-1:0]  side_i;
    logic [2*W-1:0] trial;

    if (k == 0) begin : g_in
      assign vld_i  = in_vld;
      assign rem_i  = in_val;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_chain
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = ((2*W)'(root_i) << (B + 1)) | ((2*W)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k]  <= rem_i - trial;
          root_r[k] <= root_i | (W'(1) << B);
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i;
        end
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[W-1];
  assign out_root = root_r[W-1];
  assign out_side = side_r[W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/lsas_vec.sv
`default_nettype none
module lsas_vec #(
  parameter int N  = 16,
  parameter int SW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [lsas_pkg::VIW-1:0]   in_y [2],
  input  logic signed [lsas_pkg::VIW-1:0]   in_x [2],
  input  logic [SW-1:0]                     in_side,
  output logic                              out_vld,
  output logic signed [lsas_pkg::ZW-1:0]    out_z [2],
  output logic [SW-1:0]                     out_side
);

  localparam int NS = 6;
  localparam int DW = lsas_pkg::VDW;
  localparam int ZW = lsas_pkg::ZW;

  // scaling stages
  logic                 nv_r    [NS];
  logic [SW-1:0]        ns_r    [NS];
  logic signed [DW-1:0] nx_r    [NS][2];
  logic signed [DW-1:0] ny_r    [NS][2];
  logic                 nzero_r [NS][2];

  // quadrant stage
  logic                 pv_r;
  logic [SW-1:0]        ps_r;
  logic signed [DW-1:0] px_r    [2];
  logic signed [DW-1:0] py_r    [2];
  logic signed [ZW-1:0] pz_r    [2];
  logic                 pzero_r [2];

  // rotation stages
  logic                 iv_r    [N];
  logic [SW-1:0]        is_r    [N];
  logic signed [DW-1:0] ix_r    [N][2];
  logic signed [DW-1:0] iy_r    [N][2];
  logic signed [ZW-1:0] iz_r    [N][2];
  logic                 izero_r [N][2];

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int Sh  = 32 >> j;
    localparam int Lim = lsas_pkg::NormBit + 1 - Sh;
    logic          vi;
    logic [SW-1:0] si;

    if (j == 0) begin : g_in
      assign vi = in_vld;
      assign si = in_side;
    end else begin : g_chain
      assign vi = nv_r[j-1];
      assign si = ns_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[j] <= 1'b0;
      end else if (en) begin
        nv_r[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ns_r[j] <= si;
      end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic signed [DW-1:0] xi;
      logic signed [DW-1:0] yi;
      logic [DW-1:0]        ax;
      logic [DW-1:0]        ay;
      logic                 zi;

      if (j == 0) begin : g_in
        assign xi = DW'(in_x[ln]);
        assign yi = DW'(in_y[ln]);
        assign zi = (in_x[ln] == '0) && (in_y[ln] == '0);
      end else begin : g_chain
        assign xi = nx_r[j-1][ln];
        assign yi = ny_r[j-1][ln];
        assign zi = nzero_r[j-1][ln];
      end

      assign ax = xi[DW-1] ? -xi : xi;
      assign ay = yi[DW-1] ? -yi : yi;

      always_ff @(posedge clk) begin
        if (en) begin
          if (((ax >> Lim) == '0) && ((ay >> Lim) == '0)) begin
            nx_r[j][ln] <= xi <<< Sh;
            ny_r[j][ln] <= yi <<< Sh;
          end else begin
            nx_r[j][ln] <= xi;
            ny_r[j][ln] <= yi;
          end
          nzero_r[j][ln] <= zi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= nv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r <= ns_r[NS-1];
    end
  end

  // left half plane turned by a quarter
  for (genvar ln = 0; ln < 2; ln++) begin : g_quad
    logic signed [DW-1:0] xi;
    logic signed [DW-1:0] yi;

    assign xi = nx_r[NS-1][ln];
    assign yi = ny_r[NS-1][ln];

    always_ff @(posedge clk) begin
      if (en) begin
        if (xi < 0) begin
          if (yi >= 0) begin
            px_r[ln] <= yi;
            py_r[ln] <= -xi;
            pz_r[ln] <= lsas_pkg::Deg90;
          end else begin
            px_r[ln] <= -yi;
            py_r[ln] <= xi;
            pz_r[ln] <= -lsas_pkg::Deg90;
          end
        end else begin
          px_r[ln] <= xi;
          py_r[ln] <= yi;
          pz_r[ln] <= '0;
        end
        pzero_r[ln] <= nzero_r[NS-1][ln];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [ZW-1:0] At = ZW'(lsas_pkg::atan_deg(k));
    logic          vi;
    logic [SW-1:0] si;

    if (k == 0) begin : g_in
      assign vi = pv_r;
      assign si = ps_r;
    end else begin : g_chain
      assign vi = iv_r[k-1];
      assign si = is_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        iv_r[k] <= 1'b0;
      end else if (en) begin
        iv_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        is_r[k] <= si;
      end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic signed [DW-1:0] xi;
      logic signed [DW-1:0] yi;
      logic signed [ZW-1:0] zi;
      logic                 fi;

      if (k == 0) begin : g_in
        assign xi = px_r[ln];
        assign yi = py_r[ln];
        assign zi = pz_r[ln];
        assign fi = pzero_r[ln];
      end else begin : g_chain
        assign xi = ix_r[k-1][ln];
        assign yi = iy_r[k-1][ln];
        assign zi = iz_r[k-1][ln];
        assign fi = izero_r[k-1][ln];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (yi > 0) begin
            ix_r[k][ln] <= xi + (yi >>> k);
            iy_r[k][ln] <= yi - (xi >>> k);
            iz_r[k][ln] <= zi + At;
          end else begin
            ix_r[k][ln] <= xi - (yi >>> k);
            iy_r[k][ln] <= yi + (xi >>> k);
            iz_r[k][ln] <= zi - At;
          end
          izero_r[k][ln] <= fi;
        end
      end
    end
  end

  assign out_vld  = iv_r[N-1];
  assign out_side = is_r[N-1];

  for (genvar ln = 0; ln < 2; ln++) begin : g_out
    assign out_z[ln] = izero_r[N-1][ln] ? '0 : iz_r[N-1][ln];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/linkage_servo_angle_solver_core.sv
`default_nettype none
// Servo angle solver for a plate-tilting linkage. Each plate angle (signed
// Q.8 degrees) yields one servo angle (signed Q.8 degrees) with a reachable
// flag, from the crank, link and arm lengths (unsigned Q8.8 mm) held in
// three configuration registers. The datapath is one long pipeline: a
// rotation CORDIC for the arm tip, bit-per-stage square roots for the pivot
// height, the tip distance and the sine of the crank angle, a bit-per-stage
// divider for its cosine, and a two-lane vectoring CORDIC for both angles.
// A new plate angle is taken every cycle while the pipeline is not held;
// the pipeline runs through the 81 square-root stages, the 30 divider
// stages and the two CORDIC chains besides its other registers. When the
// output register holds an untaken result the whole pipeline holds, and
// in_ready is low for that cycle.
module linkage_servo_angle_solver_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [16:0] in_plate_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_servo_angle,
  output logic               out_reachable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int N    = CORDIC_STAGES;
  localparam int ZW   = lsas_pkg::ZW;
  localparam int VIW  = lsas_pkg::VIW;
  localparam int RW   = 34;
  localparam int TW   = 28;
  localparam int PyW  = 24;
  localparam int CW   = 26;
  localparam int SbW  = 31;
  localparam int DivN = 30;
  localparam int FW   = 28;

  localparam logic signed [RW-1:0] GainInv = 34'sd652032874;
  localparam logic [30:0]          QOne    = 31'h4000_0000;
  localparam logic [61:0]          SqOne   = 62'h1000_0000_0000_0000;
  localparam logic signed [FW-1:0] OutMin  = -28'sd23040;
  localparam logic signed [FW-1:0] OutMax  = 28'sd115200;
  localparam logic signed [FW-1:0] RndHalf = 28'sd128;

  logic adv;
  logic out_valid_r;

  logic [15:0] crank_r;
  logic [15:0] link_r;
  logic [15:0] arm_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crank_r <= 16'd5376;
      link_r  <= 16'd8960;
      arm_r   <= 16'd23808;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsas_pkg::RegCrank: crank_r <= cfg_data;
        lsas_pkg::RegLink:  link_r  <= cfg_data;
        lsas_pkg::RegArm:   arm_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: fold plate angle, pivot height radicand
  logic signed [ZW-1:0] theta;
  logic signed [ZW-1:0] zf;
  logic                 negf;
  logic [31:0]          bb;
  logic [31:0]          aa;
  logic [31:0]          dsq;
  logic                 bgt;

  logic                 vld0_r;
  logic signed [ZW-1:0] z0_r;
  logic                 neg0_r;
  logic                 ok0_r;
  logic [47:0]          sqv0_r;

  assign theta = ZW'($signed({in_plate_angle, 8'h00}));
  assign bb    = link_r * link_r;
  assign aa    = crank_r * crank_r;
  assign dsq   = bb - aa;
  assign bgt   = link_r > crank_r;

  always_comb begin
    zf   = theta;
    negf = 1'b0;
    if (theta > lsas_pkg::Deg90) begin
      zf   = theta - lsas_pkg::Deg180;
      negf = 1'b1;
    end else if (theta < -lsas_pkg::Deg90) begin
      zf   = theta + lsas_pkg::Deg180;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z0_r   <= zf;
      neg0_r <= negf;
      ok0_r  <= bgt;
      sqv0_r <= bgt ? {dsq, 16'h0000} : '0;
    end
  end

  // pivot height
  logic            pyv;
  logic [PyW-1:0]  py_root;
  logic [ZW+1:0]   py_side;

  lsas_isqrt #(.W(PyW), .SW(ZW + 2)) u_py (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (vld0_r),
    .in_val   (sqv0_r),
    .in_side  ({z0_r, neg0_r, ok0_r}),
    .out_vld  (pyv),
    .out_root (py_root),
    .out_side (py_side)
  );

  // rotation cordic: cos and sin in q30
  logic                 rv_r    [N];
  logic signed [RW-1:0] rx_r    [N];
  logic signed [RW-1:0] ry_r    [N];
  logic signed [ZW-1:0] rz_r    [N];
  logic                 rneg_r  [N];
  logic                 rok_r   [N];
  logic [PyW-1:0]       rroot_r [N];

  for (genvar k = 0; k < N; k++) begin : g_rot
    localparam logic signed [ZW-1:0] At = ZW'(lsas_pkg::atan_deg(k));
    logic signed [RW-1:0] xi;
    logic signed [RW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 vi;
    logic                 negi;
    logic                 oki;
    logic [PyW-1:0]       rooti;

    if (k == 0) begin : g_in
      assign xi    = GainInv;
      assign yi    = '0;
      assign zi    = py_side[ZW+1:2];
      assign negi  = py_side[1];
      assign oki   = py_side[0];
      assign vi    = pyv;
      assign rooti = py_root;
    end else begin : g_chain
      assign xi    = rx_r[k-1];
      assign yi    = ry_r[k-1];
      assign zi    = rz_r[k-1];
      assign negi  = rneg_r[k-1];
      assign oki   = rok_r[k-1];
      assign vi    = rv_r[k-1];
      assign rooti = rroot_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k] <= 1'b0;
      end else if (adv) begin
        rv_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (zi >= 0) begin
          rx_r[k] <= xi - (yi >>> k);
          ry_r[k] <= yi + (xi >>> k);
          rz_r[k] <= zi - At;
        end else begin
          rx_r[k] <= xi + (yi >>> k);
          ry_r[k] <= yi - (xi >>> k);
          rz_r[k] <= zi + At;
        end
        rneg_r[k]  <= negi;
        rok_r[k]   <= oki;
        rroot_r[k] <= rooti;
      end
    end
  end

  // arm tip
  logic signed [RW-1:0] cx;
  logic signed [RW-1:0] sy;
  logic signed [50:0]   tpx;
  logic signed [50:0]   tpy;

  logic                 m1v_r;
  logic signed [TW-1:0] tx_r;
  logic signed [TW-1:0] ty_r;
  logic [PyW-1:0]       m1root_r;
  logic                 m1ok_r;

  assign cx  = rneg_r[N-1] ? -rx_r[N-1] : rx_r[N-1];
  assign sy  = rneg_r[N-1] ? -ry_r[N-1] : ry_r[N-1];
  assign tpx = $signed({1'b0, arm_r}) * cx;
  assign tpy = $signed({1'b0, arm_r}) * sy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
    end else if (adv) begin
      m1v_r <= rv_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r     <= tpx[49:22];
      ty_r     <= tpy[49:22];
      m1root_r <= rroot_r[N-1];
      m1ok_r   <= rok_r[N-1];
    end
  end

  // tip minus pivot
  logic                 m2v_r;
  logic signed [TW-1:0] dx2_r;
  logic signed [TW-1:0] dy2_r;
  logic                 m2ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2v_r <= 1'b0;
    end else if (adv) begin
      m2v_r <= m1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx2_r  <= tx_r - $signed({4'b0000, arm_r, 8'h00});
      dy2_r  <= ty_r + $signed({4'b0000, m1root_r});
      m2ok_r <= m1ok_r;
    end
  end

  // squared distance
  logic signed [2*TW-1:0] dxx;
  logic signed [2*TW-1:0] dyy;

  logic                 m3v_r;
  logic [2*CW-1:0]      dxsq_r;
  logic [2*CW-1:0]      dysq_r;
  logic signed [TW-1:0] dx3_r;
  logic signed [TW-1:0] dy3_r;
  logic                 m3ok_r;

  assign dxx = dx2_r * dx2_r;
  assign dyy = dy2_r * dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3v_r <= 1'b0;
    end else if (adv) begin
      m3v_r <= m2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxsq_r <= dxx[2*CW-1:0];
      dysq_r <= dyy[2*CW-1:0];
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      m3ok_r <= m2ok_r;
    end
  end

  logic            cv;
  logic [CW-1:0]   c_root;
  logic [2*TW:0]   c_side;

  lsas_isqrt #(.W(CW), .SW(2 * TW + 1)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (m3v_r),
    .in_val   (dxsq_r + dysq_r),
    .in_side  ({dx3_r, dy3_r, m3ok_r}),
    .out_vld  (cv),
    .out_root (c_root),
    .out_side (c_side)
  );

  // triangle check and law of cosines terms
  logic [16:0] lo_len;
  logic [16:0] hi_len;
  logic [23:0] aq;
  logic [23:0] bq;
  logic        rng;

  logic                 t1v_r;
  logic [47:0]          aq2_r;
  logic [47:0]          bq2_r;
  logic [51:0]          c2_r;
  logic [49:0]          aqc_r;
  logic signed [TW-1:0] dx4_r;
  logic signed [TW-1:0] dy4_r;
  logic                 rng4_r;

  assign lo_len = {1'b0, link_r} - {1'b0, crank_r};
  assign hi_len = {1'b0, link_r} + {1'b0, crank_r};
  assign aq     = {crank_r, 8'h00};
  assign bq     = {link_r, 8'h00};
  assign rng    = c_side[0] && ({1'b0, lo_len, 8'h00} < c_root) &&
                  (c_root < {1'b0, hi_len, 8'h00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1v_r <= 1'b0;
    end else if (adv) begin
      t1v_r <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aq2_r  <= aq * aq;
      bq2_r  <= bq * bq;
      c2_r   <= c_root * c_root;
      aqc_r  <= aq * c_root;
      dx4_r  <= c_side[2*TW:TW+1];
      dy4_r  <= c_side[TW:1];
      rng4_r <= rng;
    end
  end

  // numerator and denominator of cos b
  logic signed [53:0] nm;
  logic [53:0]        nabs;
  logic [50:0]        den;

  logic                 t2v_r;
  logic [50:0]          rem5_r;
  logic [50:0]          den5_r;
  logic                 nsg5_r;
  logic                 big5_r;
  logic signed [TW-1:0] dx5_r;
  logic signed [TW-1:0] dy5_r;
  logic                 rng5_r;

  assign nm   = $signed({2'b00, c2_r}) + $signed({6'd0, aq2_r}) - $signed({6'd0, bq2_r});
  assign nabs = nm[53] ? -nm : nm;
  assign den  = {aqc_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2v_r <= 1'b0;
    end else if (adv) begin
      t2v_r <= t1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem5_r <= nabs[50:0];
      den5_r <= den;
      nsg5_r <= nm[53];
      big5_r <= nabs >= {3'b000, den};
      dx5_r  <= dx4_r;
      dy5_r  <= dy4_r;
      rng5_r <= rng4_r;
    end
  end

  // restoring divider, one quotient bit per stage
  logic                 dv_r   [DivN];
  logic [50:0]          dr_r   [DivN];
  logic [DivN-1:0]      dq_r   [DivN];
  logic [50:0]          dden_r [DivN];
  logic                 dsg_r  [DivN];
  logic                 dbig_r [DivN];
  logic signed [TW-1:0] ddx_r  [DivN];
  logic signed [TW-1:0] ddy_r  [DivN];
  logic                 drng_r [DivN];

  for (genvar k = 0; k < DivN; k++) begin : g_div
    logic                 vi;
    logic [50:0]          ri;
    logic [DivN-1:0]      qi;
    logic [50:0]          di;
    logic                 sgi;
    logic                 bgi;
    logic signed [TW-1:0] dxi;
    logic signed [TW-1:0] dyi;
    logic                 rgi;
    logic [51:0]          r2;
    logic [51:0]          rs;

    if (k == 0) begin : g_in
      assign vi  = t2v_r;
      assign ri  = rem5_r;
      assign qi  = '0;
      assign di  = den5_r;
      assign sgi = nsg5_r;
      assign bgi = big5_r;
      assign dxi = dx5_r;
      assign dyi = dy5_r;
      assign rgi = rng5_r;
    end else begin : g_chain
      assign vi  = dv_r[k-1];
      assign ri  = dr_r[k-1];
      assign qi  = dq_r[k-1];
      assign di  = dden_r[k-1];
      assign sgi = dsg_r[k-1];
      assign bgi = dbig_r[k-1];
      assign dxi = ddx_r[k-1];
      assign dyi = ddy_r[k-1];
      assign rgi = drng_r[k-1];
    end

    assign r2 = {ri, 1'b0};
    assign rs = r2 - {1'b0, di};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= {1'b0, di}) begin
          dr_r[k] <= rs[50:0];
          dq_r[k] <= {qi[DivN-2:0], 1'b1};
        end else begin
          dr_r[k] <= r2[50:0];
          dq_r[k] <= {qi[DivN-2:0], 1'b0};
        end
        dden_r[k] <= di;
        dsg_r[k]  <= sgi;
        dbig_r[k] <= bgi;
        ddx_r[k]  <= dxi;
        ddy_r[k]  <= dyi;
        drng_r[k] <= rgi;
      end
    end
  end

  // cos b and the radicand of sin b
  logic [30:0] qf;

  logic                 d6v_r;
  logic signed [31:0]   cb_r;
  logic [61:0]          qq_r;
  logic signed [TW-1:0] dx6_r;
  logic signed [TW-1:0] dy6_r;
  logic                 rng6_r;

  assign qf = dbig_r[DivN-1] ? QOne : {1'b0, dq_r[DivN-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d6v_r <= 1'b0;
    end else if (adv) begin
      d6v_r <= dv_r[DivN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cb_r   <= dsg_r[DivN-1] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
      qq_r   <= qf * qf;
      dx6_r  <= ddx_r[DivN-1];
      dy6_r  <= ddy_r[DivN-1];
      rng6_r <= drng_r[DivN-1];
    end
  end

  logic             sbv;
  logic [SbW-1:0]   sb_root;
  logic [2*TW+32:0] sb_side;

  lsas_isqrt #(.W(SbW), .SW(2 * TW + 33)) u_sinb (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (d6v_r),
    .in_val   (SqOne - qq_r),
    .in_side  ({cb_r, dx6_r, dy6_r, rng6_r}),
    .out_vld  (sbv),
    .out_root (sb_root),
    .out_side (sb_side)
  );

  // lane 0: crank angle, lane 1: tip-to-pivot heading
  logic signed [VIW-1:0] vy [2];
  logic signed [VIW-1:0] vx [2];
  logic signed [ZW-1:0]  vz [2];
  logic                  vv;
  logic                  vrng;

  assign vy[0] = VIW'($signed({2'b00, sb_root}));
  assign vx[0] = VIW'($signed(sb_side[2*TW+32:2*TW+1]));
  assign vy[1] = VIW'($signed(sb_side[TW:1]));
  assign vx[1] = VIW'($signed(sb_side[2*TW:TW+1]));

  lsas_vec #(.N(N), .SW(1)) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sbv),
    .in_y     (vy),
    .in_x     (vx),
    .in_side  (sb_side[0]),
    .out_vld  (vv),
    .out_z    (vz),
    .out_side (vrng)
  );

  // final angle, rounding and clamp
  logic signed [FW-1:0] tot;
  logic signed [FW-1:0] res;
  logic signed [FW-1:0] sat;

  logic signed [17:0] out_servo_angle_r;
  logic               out_reachable_r;

  assign tot = FW'(lsas_pkg::Deg270) - (FW'(vz[1]) + FW'(vz[0])) + RndHalf;
  assign res = tot >>> 8;

  always_comb begin
    sat = res;
    if (res < OutMin) begin
      sat = OutMin;
    end else if (res > OutMax) begin
      sat = OutMax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_servo_angle_r <= vrng ? sat[17:0] : '0;
      out_reachable_r   <= vrng;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_angle = out_servo_angle_r;
  assign out_reachable   = out_reachable_r;

`ifndef ASSERT_OFF
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> (out_servo_angle == '0))
    else $error("unreachable transaction with nonzero angle");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_servo_angle >= -18'sd23040) && (out_servo_angle <= 18'sd115200)))
    else $error("servo angle outside clamp range");

  a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DivN-1] |-> (qf <= QOne))
    else $error("cosine magnitude above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(vld0_r) && $stable(t2v_r) && $stable(d6v_r)))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
